// File: hw/rtl/esit_pkg.sv
// esit_pkg: widths, payload structs, register indexes and limb helper for the
// Sampson-distance conic inlier test. No dependencies.
`default_nettype none

package esit_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int COEF_WIDTH  = 64;
  localparam int THR_WIDTH   = 32;

  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = COEF_WIDTH;

  // fixed-point alignment
  localparam int X_SHIFT   = 24;
  localparam int LIN_SHIFT = 4;
  localparam int CP2_SHIFT = 4;
  localparam int G_SHIFT   = 8;
  localparam int LHS_SHIFT = 24;
  localparam int RHS_SHIFT = 2;

  // multiplier limbs
  localparam int LIMB = 32;
  localparam int SPPW = 2 * (LIMB + 1);
  localparam int UPPW = 2 * LIMB;

  // datapath widths
  localparam int PW    = COEF_WIDTH + COORD_WIDTH;
  localparam int CP01W = PW + 2;
  localparam int CP2W  = PW + 6;
  localparam int SW    = COORD_WIDTH + CP01W + 2;
  localparam int GW    = 2 * CP01W;
  localparam int T2W   = 2 * THR_WIDTH;
  localparam int SSW   = 2 * SW;
  localparam int TGW   = T2W + GW;
  localparam int LHSW  = SSW + LHS_SHIFT;
  localparam int RHSW  = TGW + RHS_SHIFT;
  localparam int CMPW  = (LHSW > RHSW) ? LHSW : RHSW;

  localparam int NK = (COEF_WIDTH + LIMB - 1) / LIMB;
  localparam int NC = (CP01W + LIMB - 1) / LIMB;
  localparam int NS = (SW + LIMB - 1) / LIMB;
  localparam int NG = (GW + LIMB - 1) / LIMB;
  localparam int NT = (T2W + LIMB - 1) / LIMB;
  localparam int VW = LIMB * NC;

  localparam int NSTG = 9;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COEF_B    = 3'd0,
    REG_COEF_C    = 3'd1,
    REG_COEF_D    = 3'd2,
    REG_COEF_F    = 3'd3,
    REG_COEF_G    = 3'd4,
    REG_THRESHOLD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } esit_in_t;

  typedef struct packed {
    logic is_inlier;
    logic gradient_zero;
  } esit_out_t;

  // Limb k of a sign-extended value split into n limbs: lower limbs are
  // unsigned, the top limb carries the sign.
  function automatic logic signed [LIMB:0] slimb(input logic [VW-1:0] v,
                                                 input int k, input int n);
    logic [LIMB-1:0] w;
    w = v[LIMB*k +: LIMB];
    return (k == n - 1) ? $signed({w[LIMB-1], w}) : $signed({1'b0, w});
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ellipse_sampson_inlier_test_top.sv
// One item per cycle while out_ready is high; a low out_ready stalls the pipeline.
// Nine register stages of 32x32 limb products and limb sums; each stage
// holds its item when downstream stalls and refills bubbles independently.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets every
// configuration register to zero.
// Top level of the conic inlier test; depends on esit_pkg.
`default_nettype none

module ellipse_sampson_inlier_test_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  esit_pkg::esit_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output esit_pkg::esit_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [esit_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [esit_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);

  localparam int CW    = esit_pkg::COORD_WIDTH;
  localparam int KW    = esit_pkg::COEF_WIDTH;
  localparam int TW    = esit_pkg::THR_WIDTH;
  localparam int LIMB  = esit_pkg::LIMB;
  localparam int SPPW  = esit_pkg::SPPW;
  localparam int UPPW  = esit_pkg::UPPW;
  localparam int CP01W = esit_pkg::CP01W;
  localparam int CP2W  = esit_pkg::CP2W;
  localparam int SW    = esit_pkg::SW;
  localparam int GW    = esit_pkg::GW;
  localparam int T2W   = esit_pkg::T2W;
  localparam int SSW   = esit_pkg::SSW;
  localparam int TGW   = esit_pkg::TGW;
  localparam int CMPW  = esit_pkg::CMPW;
  localparam int NK    = esit_pkg::NK;
  localparam int NC    = esit_pkg::NC;
  localparam int NS    = esit_pkg::NS;
  localparam int NG    = esit_pkg::NG;
  localparam int NT    = esit_pkg::NT;
  localparam int VW    = esit_pkg::VW;
  localparam int NSTG  = esit_pkg::NSTG;

  // configuration
  logic signed [KW-1:0] coef_b_r, coef_c_r, coef_d_r, coef_f_r, coef_g_r;
  logic        [TW-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b_r <= '0;
      coef_c_r <= '0;
      coef_d_r <= '0;
      coef_f_r <= '0;
      coef_g_r <= '0;
      thr_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esit_pkg::REG_COEF_B:    coef_b_r <= $signed(cfg_wdata);
        esit_pkg::REG_COEF_C:    coef_c_r <= $signed(cfg_wdata);
        esit_pkg::REG_COEF_D:    coef_d_r <= $signed(cfg_wdata);
        esit_pkg::REG_COEF_F:    coef_f_r <= $signed(cfg_wdata);
        esit_pkg::REG_COEF_G:    coef_g_r <= $signed(cfg_wdata);
        esit_pkg::REG_THRESHOLD: thr_r    <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign in_ready  = rst_n && adv[0];
  assign out_valid = vld_r[NSTG-1];

  // stage 1: coefficient x coordinate limb products
  logic signed [CW-1:0]   x1_r, y1_r;
  logic signed [SPPW-1:0] pp_by_r [NK], pp_bx_r [NK], pp_cy_r [NK];
  logic signed [SPPW-1:0] pp_dx_r [NK], pp_fy_r [NK];
  logic signed [SPPW-1:0] pp_by_nxt [NK], pp_bx_nxt [NK], pp_cy_nxt [NK];
  logic signed [SPPW-1:0] pp_dx_nxt [NK], pp_fy_nxt [NK];

  always_comb begin
    logic signed [LIMB:0] xs, ys, bl, cl, dl, fl;
    xs = (LIMB+1)'(in_data.x_coord);
    ys = (LIMB+1)'(in_data.y_coord);
    for (int k = 0; k < NK; k++) begin
      bl = esit_pkg::slimb(VW'(coef_b_r), k, NK);
      cl = esit_pkg::slimb(VW'(coef_c_r), k, NK);
      dl = esit_pkg::slimb(VW'(coef_d_r), k, NK);
      fl = esit_pkg::slimb(VW'(coef_f_r), k, NK);
      pp_by_nxt[k] = SPPW'(bl) * SPPW'(ys);
      pp_bx_nxt[k] = SPPW'(bl) * SPPW'(xs);
      pp_cy_nxt[k] = SPPW'(cl) * SPPW'(ys);
      pp_dx_nxt[k] = SPPW'(dl) * SPPW'(xs);
      pp_fy_nxt[k] = SPPW'(fl) * SPPW'(ys);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x1_r    <= in_data.x_coord;
      y1_r    <= in_data.y_coord;
      pp_by_r <= pp_by_nxt;
      pp_bx_r <= pp_bx_nxt;
      pp_cy_r <= pp_cy_nxt;
      pp_dx_r <= pp_dx_nxt;
      pp_fy_r <= pp_fy_nxt;
    end
  end

  // stage 2: Cp = C*p
  logic signed [CW-1:0]    x2_r, y2_r;
  logic signed [CP01W-1:0] cp0_r, cp1_r, cp0_nxt, cp1_nxt;
  logic signed [CP2W-1:0]  cp2_r, cp2_nxt;

  always_comb begin
    logic signed [CP2W-1:0] lin;
    cp0_nxt = (CP01W'(x1_r) << esit_pkg::X_SHIFT)
            + (CP01W'(coef_d_r) << esit_pkg::LIN_SHIFT);
    cp1_nxt = CP01W'(coef_f_r) << esit_pkg::LIN_SHIFT;
    lin     = '0;
    for (int k = 0; k < NK; k++) begin
      cp0_nxt = cp0_nxt + (CP01W'(pp_by_r[k]) << (LIMB * k));
      cp1_nxt = cp1_nxt + (CP01W'(pp_bx_r[k]) << (LIMB * k))
                        + (CP01W'(pp_cy_r[k]) << (LIMB * k));
      lin     = lin + (CP2W'(pp_dx_r[k]) << (LIMB * k))
                    + (CP2W'(pp_fy_r[k]) << (LIMB * k));
    end
    cp2_nxt = (lin << esit_pkg::CP2_SHIFT) + (CP2W'(coef_g_r) << esit_pkg::G_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      cp0_r <= cp0_nxt;
      cp1_r <= cp1_nxt;
      cp2_r <= cp2_nxt;
    end
  end

  // stage 3: coordinate x Cp limb products, gradient magnitudes
  logic signed [SPPW-1:0]  pp_xc0_r [NC], pp_yc1_r [NC];
  logic signed [SPPW-1:0]  pp_xc0_nxt [NC], pp_yc1_nxt [NC];
  logic signed [CP2W-1:0]  cp2_3_r;
  logic        [CP01W-1:0] abs0_r, abs1_r, abs0_nxt, abs1_nxt;
  logic                    gz3_r;

  always_comb begin
    logic signed [LIMB:0] xs, ys, c0l, c1l;
    xs = (LIMB+1)'(x2_r);
    ys = (LIMB+1)'(y2_r);
    for (int k = 0; k < NC; k++) begin
      c0l = esit_pkg::slimb(VW'(cp0_r), k, NC);
      c1l = esit_pkg::slimb(VW'(cp1_r), k, NC);
      pp_xc0_nxt[k] = SPPW'(c0l) * SPPW'(xs);
      pp_yc1_nxt[k] = SPPW'(c1l) * SPPW'(ys);
    end
    abs0_nxt = cp0_r[CP01W-1] ? $unsigned(-cp0_r) : $unsigned(cp0_r);
    abs1_nxt = cp1_r[CP01W-1] ? $unsigned(-cp1_r) : $unsigned(cp1_r);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pp_xc0_r <= pp_xc0_nxt;
      pp_yc1_r <= pp_yc1_nxt;
      cp2_3_r  <= cp2_r;
      abs0_r   <= abs0_nxt;
      abs1_r   <= abs1_nxt;
      gz3_r    <= (cp0_r == '0) && (cp1_r == '0);
    end
  end

  // stage 4: residual s, gradient square limb products
  logic signed [SW-1:0]   s4_r, s4_nxt;
  logic        [UPPW-1:0] pp_a0_r [NC*NC], pp_a1_r [NC*NC];
  logic        [UPPW-1:0] pp_a0_nxt [NC*NC], pp_a1_nxt [NC*NC];
  logic                   gz4_r;

  always_comb begin
    logic [VW-1:0] a0p, a1p;
    s4_nxt = SW'(cp2_3_r);
    for (int k = 0; k < NC; k++) begin
      s4_nxt = s4_nxt + (SW'(pp_xc0_r[k]) << (LIMB * k))
                      + (SW'(pp_yc1_r[k]) << (LIMB * k));
    end
    a0p = VW'(abs0_r);
    a1p = VW'(abs1_r);
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        pp_a0_nxt[i*NC+j] = UPPW'(a0p[LIMB*i +: LIMB]) * UPPW'(a0p[LIMB*j +: LIMB]);
        pp_a1_nxt[i*NC+j] = UPPW'(a1p[LIMB*i +: LIMB]) * UPPW'(a1p[LIMB*j +: LIMB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_r    <= s4_nxt;
      pp_a0_r <= pp_a0_nxt;
      pp_a1_r <= pp_a1_nxt;
      gz4_r   <= gz3_r;
    end
  end

  // stage 5: |s|, s == 0, Cp0^2 and Cp1^2
  logic [SW-1:0] abs_s5_r, abs_s5_nxt;
  logic [GW-1:0] sq0_r, sq1_r, sq0_nxt, sq1_nxt;
  logic          sz5_r, gz5_r;

  always_comb begin
    abs_s5_nxt = s4_r[SW-1] ? $unsigned(-s4_r) : $unsigned(s4_r);
    sq0_nxt    = '0;
    sq1_nxt    = '0;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        sq0_nxt = sq0_nxt + (GW'(pp_a0_r[i*NC+j]) << (LIMB * (i + j)));
        sq1_nxt = sq1_nxt + (GW'(pp_a1_r[i*NC+j]) << (LIMB * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      abs_s5_r <= abs_s5_nxt;
      sz5_r    <= (s4_r == '0);
      sq0_r    <= sq0_nxt;
      sq1_r    <= sq1_nxt;
      gz5_r    <= gz4_r;
    end
  end

  // stage 6: gradient sum, thr^2, s^2 limb products
  logic [GW-1:0]   grad6_r;
  logic [T2W-1:0]  t2_6_r, t2_6_nxt;
  logic [UPPW-1:0] pp_ss_r [NS*NS], pp_ss_nxt [NS*NS];
  logic            sz6_r, gz6_r;

  always_comb begin
    logic [LIMB*NS-1:0] sp;
    sp       = (LIMB*NS)'(abs_s5_r);
    t2_6_nxt = T2W'(thr_r) * T2W'(thr_r);
    for (int i = 0; i < NS; i++) begin
      for (int j = 0; j < NS; j++) begin
        pp_ss_nxt[i*NS+j] = UPPW'(sp[LIMB*i +: LIMB]) * UPPW'(sp[LIMB*j +: LIMB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      grad6_r <= sq0_r + sq1_r;
      t2_6_r  <= t2_6_nxt;
      pp_ss_r <= pp_ss_nxt;
      sz6_r   <= sz5_r;
      gz6_r   <= gz5_r;
    end
  end

  // stage 7: s^2, thr^2 x gradient limb products
  logic [SSW-1:0]  ss7_r, ss7_nxt;
  logic [UPPW-1:0] pp_tg_r [NT*NG], pp_tg_nxt [NT*NG];
  logic            sz7_r, gz7_r;

  always_comb begin
    logic [LIMB*NT-1:0] tp;
    logic [LIMB*NG-1:0] gp;
    ss7_nxt = '0;
    for (int i = 0; i < NS; i++) begin
      for (int j = 0; j < NS; j++) begin
        ss7_nxt = ss7_nxt + (SSW'(pp_ss_r[i*NS+j]) << (LIMB * (i + j)));
      end
    end
    tp = (LIMB*NT)'(t2_6_r);
    gp = (LIMB*NG)'(grad6_r);
    for (int i = 0; i < NT; i++) begin
      for (int j = 0; j < NG; j++) begin
        pp_tg_nxt[i*NG+j] = UPPW'(tp[LIMB*i +: LIMB]) * UPPW'(gp[LIMB*j +: LIMB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      ss7_r   <= ss7_nxt;
      pp_tg_r <= pp_tg_nxt;
      sz7_r   <= sz6_r;
      gz7_r   <= gz6_r;
    end
  end

  // stage 8: align both sides of the comparison
  logic [CMPW-1:0] lhs8_r, rhs8_r, rhs8_nxt;
  logic            sz8_r, gz8_r;

  always_comb begin
    logic [TGW-1:0] tg;
    tg = '0;
    for (int i = 0; i < NT; i++) begin
      for (int j = 0; j < NG; j++) begin
        tg = tg + (TGW'(pp_tg_r[i*NG+j]) << (LIMB * (i + j)));
      end
    end
    rhs8_nxt = CMPW'(tg) << esit_pkg::RHS_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      lhs8_r <= CMPW'(ss7_r) << esit_pkg::LHS_SHIFT;
      rhs8_r <= rhs8_nxt;
      sz8_r  <= sz7_r;
      gz8_r  <= gz7_r;
    end
  end

  // stage 9: decision, output register
  esit_pkg::esit_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.is_inlier     = (thr_r != '0) && (sz8_r || (lhs8_r < rhs8_r));
    out_nxt.gradient_zero = gz8_r;
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // checks
  a_ready_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted item not captured in first stage");

  a_gz_rhs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[7] && gz8_r) |-> (rhs8_r == '0))
    else $error("zero gradient with nonzero right-hand side");

  a_sz_lhs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[7] |-> (sz8_r == (lhs8_r == '0)))
    else $error("zero-residual flag disagrees with s^2");

endmodule

`default_nettype wire

// File: tb/ellipse_sampson_inlier_test_top_tb.sv
// Self-checking testbench for ellipse_sampson_inlier_test_top: conic and threshold
// setups, points near and far from the curve, random stalls on both channels.
// Depends on esit_pkg and the top-level RTL only.
`default_nettype none

module ellipse_sampson_inlier_test_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int XMAX = 2 ** (esit_pkg::COORD_WIDTH - 1) - 1;
  localparam int XMIN = -(2 ** (esit_pkg::COORD_WIDTH - 1));
  localparam int ONE_Q24 = 1 << 24;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_POINTS = 125;
  localparam int LONG_HOLD = 300;
  localparam logic [esit_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [esit_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

  typedef logic signed [383:0] wide_t;
  typedef struct {
    esit_pkg::esit_in_t  pt;
    esit_pkg::esit_out_t res;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  esit_pkg::esit_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  esit_pkg::esit_out_t out_data;
  logic cfg_we = 1'b0;
  logic [esit_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [esit_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  ellipse_sampson_inlier_test_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // conic and threshold as seen by the predictor
  logic [63:0] conic_b = '0, conic_c = '0, conic_d = '0, conic_f = '0, conic_g = '0;
  logic [31:0] thr_q16 = '0;

  esit_pkg::esit_in_t pending_points[$];
  verdict_t awaited_results[$];
  int queued_total = 0, accepted_total = 0;
  int checked_count = 0, inlier_count = 0, flat_count = 0;
  int error_count = 0, setup_count = 0;
  int cycle_count = 0;
  logic in_taken = 1'b0;
  int src_gap = 0, snk_gap = 0, hold_left = 0;
  bit src_idle_on = 1'b0, snk_idle_on = 1'b0;
  bit long_hold_req = 1'b0, long_hold_taken = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic esit_pkg::esit_out_t sampson_verdict(input esit_pkg::esit_in_t pt);
    wide_t x, y, b, c, d, f, g, t, cp0, cp1, cp2, s, grad, lhs, rhs;
    esit_pkg::esit_out_t r;
    x = $signed(pt.x_coord);
    y = $signed(pt.y_coord);
    b = $signed(conic_b);
    c = $signed(conic_c);
    d = $signed(conic_d);
    f = $signed(conic_f);
    g = $signed(conic_g);
    t = {352'd0, thr_q16};
    cp0 = (x <<< 24) + b * y + (d <<< 4);
    cp1 = b * x + c * y + (f <<< 4);
    cp2 = ((d * x + f * y) <<< 4) + (g <<< 8);
    s = x * cp0 + y * cp1 + cp2;
    grad = cp0 * cp0 + cp1 * cp1;
    lhs = (s * s) <<< 24;
    rhs = ((t * t) * grad) <<< 2;
    r.gradient_zero = (cp0 == 0) && (cp1 == 0);
    r.is_inlier = (t != 0) && ((s == 0) || (lhs < rhs));
    return r;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold item until taken
    end else if (src_gap > 0) begin
      in_valid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_points.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= pending_points.pop_front();
      src_gap <= src_idle_on ? rand_gap() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (snk_idle_on && $urandom_range(0, 3) == 0) snk_gap <= rand_gap();
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    verdict_t v;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        v.pt = in_data;
        v.res = sampson_verdict(in_data);
        awaited_results = {awaited_results, v};
        accepted_total++;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no item outstanding: inlier=%0b zero_grad=%0b",
                   $time, out_data.is_inlier, out_data.gradient_zero);
          error_count++;
        end else begin
          v = awaited_results.pop_front();
          checked_count++;
          if (v.res.is_inlier) inlier_count++;
          if (v.res.gradient_zero) flat_count++;
          if (out_data.is_inlier !== v.res.is_inlier ||
              out_data.gradient_zero !== v.res.gradient_zero) begin
            $display("%0t: point (%0d, %0d) expected inlier=%0b zero_grad=%0b, got %0b %0b",
                     $time, v.pt.x_coord, v.pt.y_coord, v.res.is_inlier,
                     v.res.gradient_zero, out_data.is_inlier, out_data.gradient_zero);
            error_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [esit_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      esit_pkg::REG_COEF_B:    conic_b = val;
      esit_pkg::REG_COEF_C:    conic_c = val;
      esit_pkg::REG_COEF_D:    conic_d = val;
      esit_pkg::REG_COEF_F:    conic_f = val;
      esit_pkg::REG_COEF_G:    conic_g = val;
      esit_pkg::REG_THRESHOLD: thr_q16 = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_conic(input logic [63:0] b, c, d, f, g, input logic [31:0] thr);
    if ($urandom_range(0, 1)) write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(esit_pkg::REG_COEF_B, b);
    write_reg(esit_pkg::REG_COEF_C, c);
    write_reg(esit_pkg::REG_COEF_D, d);
    write_reg(esit_pkg::REG_COEF_F, f);
    write_reg(esit_pkg::REG_COEF_G, g);
    write_reg(esit_pkg::REG_THRESHOLD, {$urandom, thr});
    if ($urandom_range(0, 1)) write_reg(REG_SPARE_7, {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
    setup_count++;
  endtask

  // circle of radius r pixels around (cx, cy), with optional b and c
  task automatic set_circle(input int cx, cy, r, input logic [63:0] b, c,
                            input logic [31:0] thr);
    longint d, f, g;
    d = -longint'(cx) <<< 24;
    f = -longint'(cy) <<< 24;
    g = (longint'(cx) * cx + longint'(cy) * cy - longint'(r) * r) <<< 24;
    set_conic(b, c, d, f, g, thr);
  endtask

  task automatic push_point(input int x, y);
    esit_pkg::esit_in_t pt;
    pt.x_coord = x[esit_pkg::COORD_WIDTH-1:0];
    pt.y_coord = y[esit_pkg::COORD_WIDTH-1:0];
    pending_points = {pending_points, pt};
    queued_total++;
  endtask

  task automatic push_near(input int cx, cy, r);
    real th, px, py;
    th = $urandom_range(0, 62831) / 10000.0;
    px = cx + r * $cos(th) + ($itor($urandom_range(0, 200)) - 100.0) / 25.0;
    py = cy + r * $sin(th) + ($itor($urandom_range(0, 200)) - 100.0) / 25.0;
    push_point($rtoi(px * 16.0), $rtoi(py * 16.0));
  endtask

  function automatic int pick_extreme();
    int k;
    k = $urandom_range(0, 3);
    return (k == 0) ? XMAX : (k == 1) ? XMIN : (k == 2) ? 0 : -1;
  endfunction

  // sender pause: wait for every item to go in and every result to come back
  task automatic settle();
    int waited;
    waited = 0;
    while (accepted_total != queued_total) @(negedge clk);
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      error_count += awaited_results.size();
      awaited_results.delete();
    end
    repeat (esit_pkg::NSTG + 4) @(negedge clk);
  endtask

  initial begin
    int kind, cx, cy, r, sel;
    logic [63:0] b, c;
    logic [31:0] thr;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    // reset setup: zero threshold, no inliers
    push_point(0, 0);
    push_point(XMAX, XMAX);
    push_point(XMIN, XMIN);
    push_point(XMAX, XMIN);
    push_point(XMIN, XMAX);
    settle();

    // radius 100 circle, 1 px threshold; spare indexes must not disturb it
    set_circle(0, 0, 100, 64'd0, 64'(ONE_Q24), 32'h0001_0000);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    @(negedge clk);
    cfg_we <= 1'b0;
    push_point(1600, 0);
    push_point(0, 1600);
    push_point(1616, 0);
    push_point(1632, 0);
    push_point(-1600, 0);
    push_point(0, 0);  // center: flat gradient, nonzero residual
    settle();

    // degenerate circle: flat gradient and zero residual at its center
    set_circle(10, -20, 0, 64'd0, 64'(ONE_Q24), 32'hFFFF_FFFF);
    push_point(160, -320);
    push_point(161, -320);
    push_point(0, 0);
    settle();

    set_conic(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
              64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_point(XMAX, XMAX);
    push_point(XMIN, XMIN);
    push_point(0, 0);
    settle();

    set_conic(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'd1);
    push_point(XMAX, XMIN);
    push_point(XMIN, XMAX);
    push_point(1, -1);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      kind = p % 4;
      src_idle_on = (p % 3 != 1);
      snk_idle_on = (p % 5 != 2);
      cx = $urandom_range(0, 2000) - 1000;
      cy = $urandom_range(0, 2000) - 1000;
      r = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1000);
      b = 64'd0;
      c = 64'(ONE_Q24);
      thr = $urandom_range(1 << 15, 4 << 16);
      if (kind == 2) begin
        set_conic({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end else begin
        if (kind == 3) begin
          b = 64'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
          c = 64'($urandom_range(1 << 22, 1 << 26));
          sel = $urandom_range(0, 2);
          thr = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
        end
        set_circle(cx, cy, r, b, c, thr);
      end
      if (p == 5) long_hold_req = 1'b1;
      for (int i = 0; i < PHASE_POINTS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) push_near(cx, cy, r);
        else if (sel < 90) push_point($urandom, $urandom);
        else if (sel < 95) push_point(cx * 16, cy * 16);
        else push_point(pick_extreme(), pick_extreme());
      end
      settle();
    end

    $display("Checked %0d points under %0d conic setups: %0d inliers, %0d flat gradients",
             checked_count, setup_count, inlier_count, flat_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
